// ===== rtl/core/apmq_pkg.sv =====
// shared constants and types for the alarm priority message queue
package apmq_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int WORD_BITS  = 32;

  // port widths fixed by the interface
  localparam int PORT_W  = 32;
  localparam int TOTAL_W = 5;

  // derived widths
  localparam int DATA_W  = (WORD_BITS < PORT_W) ? WORD_BITS : PORT_W;
  localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int COUNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W   = (COUNT_W + 1 > TOTAL_W) ? COUNT_W + 1 : TOTAL_W;

  localparam logic FUNC_SEND    = 1'b0;
  localparam logic FUNC_RECEIVE = 1'b1;

  localparam logic KIND_NORMAL = 1'b0;
  localparam logic KIND_ALARM  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_ROOM = 2'd1,
    STATUS_NO_MSG  = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

endpackage

// ===== rtl/core/apmq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module apmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/alarm_priority_message_queue.sv =====
// top level of the alarm priority message queue
//
// usage
//   command channel: a beat is taken at a rising edge with start high and
//   busy low. func selects send or receive; kind_in and payload_in matter
//   only on a send.
//   result channel: done is high for exactly one cycle per command and
//   qualifies status, payload_out, kind_out, total_count and alarm_count.
//   the receiver cannot stall, so every result is taken in its done cycle.
// timing
//   sends, alarm receives and refused commands: result in the cycle after the
//   beat, a new command every cycle.
//   receives served from the fifo: the result passes through the fetch state,
//   with busy high for one cycle while the fifo ram read completes, so no new
//   command is taken during the fetch state.
// reset
//   rst is synchronous, active high; it empties the fifo and the alarm slot.
//   the ram needs no clearing since only counted entries are read.
module alarm_priority_message_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic                           kind_in,
  input  logic [apmq_pkg::PORT_W-1:0]    payload_in,
  output logic                           done,
  output apmq_pkg::status_t              status,
  output logic [apmq_pkg::PORT_W-1:0]    payload_out,
  output logic                           kind_out,
  output logic [apmq_pkg::TOTAL_W-1:0]   total_count,
  output logic                           alarm_count
);

  import apmq_pkg::*;

  // control state
  state_t             state;
  logic [PTR_W-1:0]   read_pointer;
  logic [PTR_W-1:0]   write_pointer;
  logic [COUNT_W-1:0] normal_count;
  logic               alarm_held;
  logic [DATA_W-1:0]  alarm_word;

  // decode of the accepted beat
  logic               accept;
  logic               fifo_write;
  logic               fifo_read;
  logic               take_alarm;
  logic               set_alarm;
  status_t            status_next;
  logic [COUNT_W-1:0] normal_count_next;
  logic               alarm_held_next;
  logic [SUM_W-1:0]   total_sum;
  logic [DATA_W-1:0]  word_in;
  logic [DATA_W-1:0]  ram_rdata;

  function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign busy    = (state == ST_FETCH);
  assign accept  = start && !busy;
  assign word_in = payload_in[DATA_W-1:0];

  always_comb begin
    fifo_write        = 1'b0;
    fifo_read         = 1'b0;
    take_alarm        = 1'b0;
    set_alarm         = 1'b0;
    status_next       = STATUS_OK;
    normal_count_next = normal_count;
    alarm_held_next   = alarm_held;
    if (func == FUNC_SEND) begin
      if (kind_in == KIND_ALARM) begin
        // only one alarm slot
        if (alarm_held) begin
          status_next = STATUS_NO_ROOM;
        end else begin
          set_alarm       = 1'b1;
          alarm_held_next = 1'b1;
        end
      end else if (normal_count == COUNT_W'(FIFO_DEPTH)) begin
        status_next = STATUS_FULL;
      end else begin
        fifo_write        = 1'b1;
        normal_count_next = normal_count + 1'b1;
      end
    end else begin
      // alarm is served ahead of the fifo head
      if (alarm_held) begin
        take_alarm      = 1'b1;
        alarm_held_next = 1'b0;
      end else if (normal_count != '0) begin
        fifo_read         = 1'b1;
        normal_count_next = normal_count - 1'b1;
      end else begin
        status_next = STATUS_NO_MSG;
      end
    end
  end

  assign total_sum = SUM_W'(normal_count_next) + SUM_W'(alarm_held_next);

  // fifo storage; the read address is the head at the time of the beat,
  // so rdata holds the head word in the fetch cycle
  apmq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && fifo_write),
    .waddr (write_pointer),
    .wdata (word_in),
    .raddr (read_pointer),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      read_pointer  <= '0;
      write_pointer <= '0;
      normal_count  <= '0;
      alarm_held    <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            normal_count <= normal_count_next;
            alarm_held   <= alarm_held_next;
            if (fifo_write) begin
              write_pointer <= next_index(write_pointer);
            end
            if (fifo_read) begin
              // result waits for the ram read
              read_pointer <= next_index(read_pointer);
              state        <= ST_FETCH;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_FETCH: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload side, no reset needed
  always_ff @(posedge clk) begin
    if (accept && set_alarm) begin
      alarm_word <= word_in;
    end
    if (accept) begin
      status      <= status_next;
      kind_out    <= take_alarm;
      total_count <= total_sum[TOTAL_W-1:0];
      alarm_count <= alarm_held_next;
      if (take_alarm) begin
        payload_out <= PORT_W'(alarm_word);
      end else begin
        payload_out <= '0;
      end
    end else if (state == ST_FETCH) begin
      payload_out <= PORT_W'(ram_rdata);
    end
  end

endmodule
